// ----- rtl/core/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, state codes and constants of the load pulse sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned AmpW    = 32;
  localparam int unsigned NanoW   = 30;
  localparam int unsigned StateW  = 4;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [31:0] NanoPerUnit = 32'd1000000000;

  // sequencer states
  localparam logic [StateW-1:0] StL1Setup   = 4'd0;
  localparam logic [StateW-1:0] StL1On      = 4'd1;
  localparam logic [StateW-1:0] StL1Idle    = 4'd2;
  localparam logic [StateW-1:0] StL2Setup   = 4'd3;
  localparam logic [StateW-1:0] StL2On      = 4'd4;
  localparam logic [StateW-1:0] StL2Idle    = 4'd5;
  localparam logic [StateW-1:0] StBothSetup = 4'd6;
  localparam logic [StateW-1:0] StBothOn    = 4'd7;
  localparam logic [StateW-1:0] StEndIdle   = 4'd8;

  // finished phase codes
  localparam logic [PhaseW-1:0] PhLoadOne = 2'd0;
  localparam logic [PhaseW-1:0] PhLoadTwo = 2'd1;
  localparam logic [PhaseW-1:0] PhBoth    = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLoad1On   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLoad1Idle = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLoad2On   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLoad2Idle = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBothOn    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegEndIdle   = 3'd5;

  // configuration reset values
  localparam logic [TimeW-1:0] Load1OnRst   = 32'd30000;
  localparam logic [TimeW-1:0] Load1IdleRst = 32'd1000;
  localparam logic [TimeW-1:0] Load2OnRst   = 32'd3000;
  localparam logic [TimeW-1:0] Load2IdleRst = 32'd0;
  localparam logic [TimeW-1:0] BothOnRst    = 32'd0;
  localparam logic [TimeW-1:0] EndIdleRst   = 32'd60000;

  typedef struct packed {
    logic [TimeW-1:0] load1_on_ms;
    logic [TimeW-1:0] load1_idle_ms;
    logic [TimeW-1:0] load2_on_ms;
    logic [TimeW-1:0] load2_idle_ms;
    logic [TimeW-1:0] both_on_ms;
    logic [TimeW-1:0] end_idle_ms;
  } lps_cfg_t;

  typedef struct packed {
    logic              load_one_on;
    logic              load_two_on;
    logic              phase_done;
    logic [PhaseW-1:0] finished_phase;
    logic [AmpW-1:0]   charge_delta;
    logic [StateW-1:0] sequencer_state;
  } lps_result_t;

endpackage

// ----- rtl/core/load_pulse_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// load_pulse_sequencer_unit
// Millisecond-tick load pulse sequencer with charge accounting per phase.
// ----------------------------------------------------------------------------
// Path: the input word's accept edge loads the input register; the result
//   register is written when the tick is consumed, which back-pressure on
//   the result channel can hold off.
// Throughput: one word per cycle while the result channel is not stalled; the
//   state update is a single pass, so a new tick is taken as the last is consumed.
// Reset: asynchronous, active low; state goes to load one setup with both
//   loads off and the timing registers take their default values.
module load_pulse_sequencer_unit import lps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  // input ticks
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [63:0]        s_axis_tdata_i,  // [31:0] charge_amp_hours,
                                              // [61:32] charge_nano_amp_hours
  input  logic               s_axis_tuser_i,  // [0] abort
  // results
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [39:0]        m_axis_tdata_o,  // [0] load_one_on, [1] load_two_on,
                                              // [33:2] charge_delta,
                                              // [37:34] sequencer_state
  output logic [2:0]         m_axis_tuser_o   // [0] phase_done,
                                              // [2:1] finished_phase
);

  // Configuration is always taken; the user must write only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  lps_cfg_t cfg;

  lps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // ---- input register --------------------------------------------------
  logic             in_vld_q;
  logic             abort_q;
  logic [AmpW-1:0]  amp_q;
  logic [NanoW-1:0] nano_q;
  logic             in_fire, step;

  // The tick is consumed when the result register is empty or drains now.
  assign step            = in_vld_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || step;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      abort_q <= s_axis_tuser_i;
      amp_q   <= s_axis_tdata_i[31:0];
      nano_q  <= s_axis_tdata_i[61:32];
    end
  end

  // ---- sequencer -------------------------------------------------------
  lps_result_t res;

  lps_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .abort_i  (abort_q),
    .amp_i    (amp_q),
    .nano_i   (nano_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  // ---- result register -------------------------------------------------
  logic        out_vld_q;
  lps_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, res_q.sequencer_state, res_q.charge_delta,
                            res_q.load_two_on, res_q.load_one_on};
  assign m_axis_tuser_o  = {res_q.finished_phase, res_q.phase_done};

  // ---- checks ----------------------------------------------------------
  // A finished phase has switched its load(s) off.
  a_done_load_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.phase_done && res_q.finished_phase == PhLoadOne)
      |-> !res_q.load_one_on)
    else $error("load one still on after its phase ended");

  a_done_both_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.phase_done && res_q.finished_phase == PhBoth)
      |-> (!res_q.load_one_on && !res_q.load_two_on))
    else $error("a load still on after the both phase ended");

  // Reported state is always a real state.
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.sequencer_state <= StEndIdle))
    else $error("sequencer reported an unused state code");

  // No delta without a finished phase.
  a_delta_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.phase_done) |-> (res_q.charge_delta == '0))
    else $error("charge delta reported without a finished phase");

endmodule

// ----- rtl/core/lps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lps_cfg_regs
// Phase timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module lps_cfg_regs import lps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [TimeW-1:0]   wr_data_i,
  output lps_cfg_t           cfg_o
);

  lps_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        RegLoad1On:   cfg_d.load1_on_ms   = wr_data_i;
        RegLoad1Idle: cfg_d.load1_idle_ms = wr_data_i;
        RegLoad2On:   cfg_d.load2_on_ms   = wr_data_i;
        RegLoad2Idle: cfg_d.load2_idle_ms = wr_data_i;
        RegBothOn:    cfg_d.both_on_ms    = wr_data_i;
        RegEndIdle:   cfg_d.end_idle_ms   = wr_data_i;
        default: ;    // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load1_on_ms   <= Load1OnRst;
      cfg_q.load1_idle_ms <= Load1IdleRst;
      cfg_q.load2_on_ms   <= Load2OnRst;
      cfg_q.load2_idle_ms <= Load2IdleRst;
      cfg_q.both_on_ms    <= BothOnRst;
      cfg_q.end_idle_ms   <= EndIdleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/lps_seq.sv -----
// ----------------------------------------------------------------------------
// lps_seq
// Phase state machine: state registers and the one-tick update.
// ----------------------------------------------------------------------------
module lps_seq import lps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             abort_i,
  input  logic [AmpW-1:0]  amp_i,
  input  logic [NanoW-1:0] nano_i,
  input  lps_cfg_t         cfg_i,
  output lps_result_t      result_o
);

  logic [StateW-1:0] state_q, state_d;
  logic [TimeW-1:0]  ticks_q, ticks_d, ticks_act;
  logic [AmpW-1:0]   start_amp_q, start_amp_d;
  logic [NanoW-1:0]  start_nano_q, start_nano_d;
  logic [1:0]        drive_q, drive_d;
  logic              done;
  logic [PhaseW-1:0] which;
  logic [AmpW-1:0]   delta, amp_diff, amp_scaled;
  logic              ticks_zero;

  // delta = (a - sa) * 1e9 + (n - sn), all mod 2^32
  assign amp_diff   = amp_i - start_amp_q;
  assign amp_scaled = amp_diff * NanoPerUnit;
  assign delta      = amp_scaled + {2'b00, nano_i} - {2'b00, start_nano_q};

  assign ticks_zero = (ticks_q == '0);

  always_comb begin
    state_d      = state_q;
    ticks_act    = ticks_q;
    start_amp_d  = start_amp_q;
    start_nano_d = start_nano_q;
    drive_d      = drive_q;
    done         = 1'b0;
    which        = PhLoadOne;
    unique case (state_q)
      StL1On: begin
        if (ticks_zero) begin
          drive_d[0] = 1'b0;
          done       = 1'b1;
          which      = PhLoadOne;
          ticks_act  = cfg_i.load1_idle_ms;
          state_d    = StL1Idle;
        end
      end
      StL1Idle: begin
        if (ticks_zero) state_d = StL2Setup;
      end
      StL2Setup: begin
        if (cfg_i.load2_on_ms != '0) begin
          start_amp_d  = amp_i;
          start_nano_d = nano_i;
          drive_d[1]   = 1'b1;
          ticks_act    = cfg_i.load2_on_ms;
          state_d      = StL2On;
        end else begin
          ticks_act = cfg_i.load2_idle_ms;
          state_d   = StL2Idle;
        end
      end
      StL2On: begin
        if (ticks_zero) begin
          drive_d[1] = 1'b0;
          done       = 1'b1;
          which      = PhLoadTwo;
          ticks_act  = cfg_i.load2_idle_ms;
          state_d    = StL2Idle;
        end
      end
      StL2Idle: begin
        if (ticks_zero) state_d = StBothSetup;
      end
      StBothSetup: begin
        if (cfg_i.both_on_ms != '0) begin
          start_amp_d  = amp_i;
          start_nano_d = nano_i;
          drive_d      = 2'b11;
          ticks_act    = cfg_i.both_on_ms;
          state_d      = StBothOn;
        end else begin
          ticks_act = cfg_i.end_idle_ms;
          state_d   = StEndIdle;
        end
      end
      StBothOn: begin
        if (ticks_zero) begin
          drive_d   = 2'b00;
          done      = 1'b1;
          which     = PhBoth;
          ticks_act = cfg_i.end_idle_ms;
          state_d   = StEndIdle;
        end
      end
      StEndIdle: begin
        if (ticks_zero) state_d = StL1Setup;
      end
      default: begin  // load one setup, unused codes behave the same
        if (cfg_i.load1_on_ms != '0) begin
          start_amp_d  = amp_i;
          start_nano_d = nano_i;
          drive_d[0]   = 1'b1;
          ticks_act    = cfg_i.load1_on_ms;
          state_d      = StL1On;
        end else begin
          ticks_act = cfg_i.load1_idle_ms;
          state_d   = StL1Idle;
        end
      end
    endcase

    ticks_d = (ticks_act != '0) ? ticks_act - TimeW'(1) : ticks_act;

    if (abort_i) begin
      drive_d = 2'b00;
      state_d = StL1Setup;
      ticks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StL1Setup;
      ticks_q      <= '0;
      start_amp_q  <= '0;
      start_nano_q <= '0;
      drive_q      <= 2'b00;
    end else if (step_i) begin
      state_q      <= state_d;
      ticks_q      <= ticks_d;
      start_amp_q  <= start_amp_d;
      start_nano_q <= start_nano_d;
      drive_q      <= drive_d;
    end
  end

  always_comb begin
    result_o.load_one_on     = drive_d[0];
    result_o.load_two_on     = drive_d[1];
    result_o.phase_done      = done;
    result_o.finished_phase  = done ? which : PhLoadOne;
    result_o.charge_delta    = done ? delta : '0;
    result_o.sequencer_state = state_d;
  end

endmodule
